/* rtl/fsg_pkg.sv */
package fsg_pkg;

   localparam int unsigned HISTORY_DEPTH_DEFAULT = 64;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned REP_W = 8;
   localparam int unsigned STATUS_W = 4;
   localparam int unsigned KEY_W = 4 * WORD_W + REP_W;

   localparam logic [WORD_W-1:0] WORD_MAX = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 4'd0,
      ST_RETIRED   = 4'd1,
      ST_DECODE    = 4'd2,
      ST_STALE     = 4'd3,
      ST_FULL      = 4'd4,
      ST_BACKWARDS = 4'd5,
      ST_PUB_EXH   = 4'd6,
      ST_REV_EXH   = 4'd7,
      ST_RESET_EXH = 4'd8
   } status_type;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic             cmd;
      logic [WORD_W-1:0] generation;
      logic             decode_ok;
      logic [WORD_W-1:0] frame_source;
      logic [WORD_W-1:0] frame_epoch;
      logic [WORD_W-1:0] calib_code;
      logic [REP_W-1:0]  representation;
      logic [WORD_W-1:0] map_gen_id;
      logic [WORD_W-1:0] sequence_number;
      logic [WORD_W-1:0] receipt_time;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] stream_gen;
      logic [WORD_W-1:0] publication_count;
      logic [WORD_W-1:0] id_revision;
   } rsp_type;

   function automatic key_type make_key(req_type r);
      return {r.frame_source, r.frame_epoch, r.calib_code, r.representation,
              r.map_gen_id};
   endfunction

endpackage

/* rtl/fsg_req_if.sv */
interface fsg_req_if;
   logic            valid;
   logic            ready;
   fsg_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/fsg_rsp_if.sv */
interface fsg_rsp_if;
   logic            valid;
   logic            ready;
   fsg_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/frame_sequence_gatekeeper.sv */
// Frame sequence gatekeeper.
// req (sink): one item is a publish (cmd 0) or a mailbox reset (cmd 1), taken
// when valid and ready are both high. rsp (source): exactly one result item per
// request, carrying the status and the three counters after the item.
// A publish scans the identity table one entry per cycle through a single
// memory read port and one key comparator; after the scan it passes through
// S_LAST, S_READ and S_DECIDE before its result is offered in S_OUT, and
// the next item can be taken once that result has been taken.
// A publish that fails the generation or decode check, and any mailbox reset,
// gives its result in the cycle after acceptance.
// One item is in work at a time; req_ready is low from acceptance until the
// result item has been taken, so a stalled receiver holds the result in the
// output register and simply delays the next request.
// After reset the table is empty (per-entry used bits cleared at once), all
// counters are zero and the block is ready in the first cycle.
// A mailbox reset that is not refused for an exhausted counter clears the used
// bits at acceptance; the table memory keeps old contents, masked from every match.
module frame_sequence_gatekeeper #(
   parameter int unsigned HISTORY_DEPTH = fsg_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fsg_req_if.sink    req,
   fsg_rsp_if.source  rsp
);
   localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(HISTORY_DEPTH - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_LAST  = 6'b000100,
      S_READ  = 6'b001000,
      S_DECIDE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   fsg_pkg::req_type item_ff;
   fsg_pkg::rsp_type rsp_ff;

   // Identity table: keys and last sequence numbers in memories.
   fsg_pkg::key_type key_mem [HISTORY_DEPTH];
   logic [fsg_pkg::WORD_W-1:0] seq_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] used_ff;

   logic [CNT_W-1:0] scan_ff;       // address being read
   logic [IDX_W-1:0] cmp_idx_ff;    // address whose data is in key_rd_ff
   logic             cmp_vld_ff;
   fsg_pkg::key_type key_rd_ff;
   logic [fsg_pkg::WORD_W-1:0] seq_rd_ff;
   logic             found_ff, free_ok_ff;
   logic [IDX_W-1:0] found_idx_ff, free_idx_ff;

   logic             has_frame_ff;
   logic [fsg_pkg::WORD_W-1:0] last_receipt_ff, gen_ff, pub_ff, rev_ff;
   fsg_pkg::key_type cur_key_ff;

   fsg_pkg::key_type item_key;
   logic hit;
   logic write_en;
   fsg_pkg::status_type dec_status;
   logic changed;

   assign item_key = fsg_pkg::make_key(item_ff);
   assign hit = cmp_vld_ff && used_ff[cmp_idx_ff] && (key_rd_ff == item_key);
   assign changed = !has_frame_ff || (cur_key_ff != item_key);

   always_comb begin
      if (found_ff && item_ff.sequence_number <= seq_rd_ff) begin
         dec_status = fsg_pkg::ST_STALE;
      end else if (!found_ff && !free_ok_ff) begin
         dec_status = fsg_pkg::ST_FULL;
      end else if (has_frame_ff && item_ff.receipt_time < last_receipt_ff) begin
         dec_status = fsg_pkg::ST_BACKWARDS;
      end else if (pub_ff == fsg_pkg::WORD_MAX) begin
         dec_status = fsg_pkg::ST_PUB_EXH;
      end else if (changed && rev_ff == fsg_pkg::WORD_MAX) begin
         dec_status = fsg_pkg::ST_REV_EXH;
      end else begin
         dec_status = fsg_pkg::ST_OK;
      end
   end

   assign write_en = (state_ff == S_DECIDE) && (dec_status == fsg_pkg::ST_OK);

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.payload.cmd || req.payload.generation == '0 ||
                   req.payload.generation != gen_ff || !req.payload.decode_ok) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN:   if (scan_ff == LAST_IDX) state_in = S_LAST;
         S_LAST:   state_in = S_READ;
         S_READ:   state_in = S_DECIDE;
         S_DECIDE: state_in = S_OUT;
         S_OUT:    if (rsp.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory ports: read in scan, reread the hit entry, write on success.
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         key_rd_ff <= key_mem[scan_ff[IDX_W-1:0]];
      end
      if (state_ff == S_READ) begin
         seq_rd_ff <= seq_mem[found_idx_ff];
      end
      if (write_en) begin
         seq_mem[found_ff ? found_idx_ff : free_idx_ff] <= item_ff.sequence_number;
         if (!found_ff) key_mem[free_idx_ff] <= item_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         has_frame_ff <= 1'b0;
         last_receipt_ff <= '0;
         cur_key_ff <= '0;
         gen_ff <= '0;
         pub_ff <= '0;
         rev_ff <= '0;
         cmp_vld_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               item_ff <= req.payload;
               scan_ff <= '0;
               cmp_vld_ff <= 1'b0;
               found_ff <= 1'b0;
               free_ok_ff <= 1'b0;
               found_idx_ff <= '0;
               free_idx_ff <= '0;
               if (req.valid) begin
                  rsp_ff.stream_gen <= gen_ff;
                  rsp_ff.publication_count <= pub_ff;
                  rsp_ff.id_revision <= rev_ff;
                  if (req.payload.cmd) begin
                     if (gen_ff == fsg_pkg::WORD_MAX || pub_ff == fsg_pkg::WORD_MAX) begin
                        rsp_ff.status <= fsg_pkg::ST_RESET_EXH;
                     end else begin
                        rsp_ff.status <= fsg_pkg::ST_OK;
                        used_ff <= '0;
                        has_frame_ff <= 1'b0;
                        last_receipt_ff <= '0;
                        cur_key_ff <= '0;
                        rev_ff <= '0;
                        gen_ff <= gen_ff + 1'b1;
                        pub_ff <= pub_ff + 1'b1;
                        rsp_ff.stream_gen <= gen_ff + 1'b1;
                        rsp_ff.publication_count <= pub_ff + 1'b1;
                        rsp_ff.id_revision <= '0;
                     end
                  end else if (req.payload.generation == '0 ||
                               req.payload.generation != gen_ff) begin
                     rsp_ff.status <= fsg_pkg::ST_RETIRED;
                  end else begin
                     rsp_ff.status <= fsg_pkg::ST_DECODE;
                  end
               end
            end
            S_SCAN, S_LAST, S_READ: begin
               // Compare the entry read last cycle; first hit and first free win.
               if (state_ff == S_SCAN) begin
                  scan_ff <= scan_ff + 1'b1;
                  cmp_idx_ff <= scan_ff[IDX_W-1:0];
                  cmp_vld_ff <= 1'b1;
               end else begin
                  cmp_vld_ff <= 1'b0;
               end
               if (cmp_vld_ff) begin
                  if (hit && !found_ff) begin
                     found_ff <= 1'b1;
                     found_idx_ff <= cmp_idx_ff;
                  end
                  if (!used_ff[cmp_idx_ff] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_idx_ff <= cmp_idx_ff;
                  end
               end
            end
            S_DECIDE: begin
               rsp_ff.status <= dec_status;
               if (write_en) begin
                  if (!found_ff) used_ff[free_idx_ff] <= 1'b1;
                  if (changed) rev_ff <= rev_ff + 1'b1;
                  has_frame_ff <= 1'b1;
                  cur_key_ff <= item_key;
                  last_receipt_ff <= item_ff.receipt_time;
                  pub_ff <= pub_ff + 1'b1;
                  rsp_ff.publication_count <= pub_ff + 1'b1;
                  rsp_ff.id_revision <= changed ? rev_ff + 1'b1 : rev_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // The found slot must be a used entry, and the free slot an unused one.
   a_found_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && found_ff) |-> used_ff[found_idx_ff])
      else $error("hit on unused table entry");
   a_free_unused: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && free_ok_ff) |-> !used_ff[free_idx_ff])
      else $error("free slot already used");
   a_pub_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> $stable(pub_ff))
      else $error("publication counter moved outside an item");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp_ff)))
      else $error("result dropped under stall");
endmodule

/* tb/fsg_checker.sv */
module fsg_checker (
   input  logic  clock,
   input  logic  reset,
   fsg_req_if    req,
   fsg_rsp_if    rsp,
   output int    errors,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = int'(fsg_pkg::HISTORY_DEPTH_DEFAULT);

   fsg_pkg::key_type           id_key [DEPTH];
   logic [fsg_pkg::WORD_W-1:0] id_last_seq [DEPTH];
   bit                         id_used [DEPTH];
   bit                         frame_valid;
   fsg_pkg::key_type           frame_key;
   logic [fsg_pkg::WORD_W-1:0] frame_time;
   logic [fsg_pkg::WORD_W-1:0] gen_now;
   logic [fsg_pkg::WORD_W-1:0] pub_now;
   logic [fsg_pkg::WORD_W-1:0] rev_now;
   fsg_pkg::rsp_type           expected_rsp [$];

   assign pending = expected_rsp.size();

   function automatic void clear_mailbox();
      foreach (id_used[i]) id_used[i] = 1'b0;
      frame_valid = 1'b0;
      frame_key = '0;
      frame_time = '0;
      rev_now = '0;
   endfunction

   function automatic fsg_pkg::status_type gate_publish(fsg_pkg::req_type r);
      fsg_pkg::key_type k;
      int hit;
      int free_at;
      bit changed;
      k = {r.frame_source, r.frame_epoch, r.calib_code, r.representation,
           r.map_gen_id};
      hit = -1;
      free_at = -1;
      if (r.generation == '0 || r.generation != gen_now) return fsg_pkg::ST_RETIRED;
      if (!r.decode_ok) return fsg_pkg::ST_DECODE;
      for (int i = 0; i < DEPTH; i++) begin
         if (id_used[i]) begin
            if (hit < 0 && id_key[i] == k) hit = i;
         end else if (free_at < 0) begin
            free_at = i;
         end
      end
      if (hit >= 0 && r.sequence_number <= id_last_seq[hit]) return fsg_pkg::ST_STALE;
      if (hit < 0 && free_at < 0) return fsg_pkg::ST_FULL;
      if (frame_valid && r.receipt_time < frame_time) return fsg_pkg::ST_BACKWARDS;
      if (pub_now == fsg_pkg::WORD_MAX) return fsg_pkg::ST_PUB_EXH;
      changed = !frame_valid || frame_key != k;
      if (changed && rev_now == fsg_pkg::WORD_MAX) return fsg_pkg::ST_REV_EXH;
      if (hit < 0) begin
         hit = free_at;
         id_used[hit] = 1'b1;
         id_key[hit] = k;
      end
      id_last_seq[hit] = r.sequence_number;
      if (changed) rev_now++;
      frame_valid = 1'b1;
      frame_key = k;
      frame_time = r.receipt_time;
      pub_now++;
      return fsg_pkg::ST_OK;
   endfunction

   function automatic fsg_pkg::rsp_type predict_outcome(fsg_pkg::req_type r);
      fsg_pkg::rsp_type o;
      if (r.cmd) begin
         if (gen_now == fsg_pkg::WORD_MAX || pub_now == fsg_pkg::WORD_MAX) begin
            o.status = fsg_pkg::ST_RESET_EXH;
         end else begin
            clear_mailbox();
            gen_now++;
            pub_now++;
            o.status = fsg_pkg::ST_OK;
         end
      end else begin
         o.status = gate_publish(r);
      end
      o.stream_gen = gen_now;
      o.publication_count = pub_now;
      o.id_revision = rev_now;
      return o;
   endfunction

   always @(posedge clock) begin
      fsg_pkg::rsp_type want;
      if (reset) begin
         clear_mailbox();
         gen_now = '0;
         pub_now = '0;
         expected_rsp.delete();
         errors = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result item with no expectation waiting");
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.payload.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status,
                         rsp.payload.status);
                  errors++;
               end
               if (rsp.payload.stream_gen !== want.stream_gen) begin
                  $error("stream_gen expected %0d actual %0d",
                         want.stream_gen, rsp.payload.stream_gen);
                  errors++;
               end
               if (rsp.payload.publication_count !== want.publication_count) begin
                  $error("publication_count expected %0d actual %0d",
                         want.publication_count, rsp.payload.publication_count);
                  errors++;
               end
               if (rsp.payload.id_revision !== want.id_revision) begin
                  $error("id_revision expected %0d actual %0d",
                         want.id_revision, rsp.payload.id_revision);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_rsp = {expected_rsp, predict_outcome(req.payload)};
         end
      end
   end

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int POOL_SIZE = 6;
   localparam int REQ_W = $bits(fsg_pkg::req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   pending;
   int   cycles = 0;
   int   stall_left = 0;

   fsg_req_if req ();
   fsg_rsp_if rsp ();

   frame_sequence_gatekeeper uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   fsg_checker check (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                      .errors(errors), .pending(pending));

   // Stimulus-side view of the mailbox, kept just well enough to form legal frames.
   logic [fsg_pkg::WORD_W-1:0] live_gen = '0;
   logic [fsg_pkg::WORD_W-1:0] seq_run = 64'd10;
   logic [fsg_pkg::WORD_W-1:0] time_run = 64'd100;
   fsg_pkg::req_type           pool [POOL_SIZE];

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // The receiver stalls in short bursts mostly, with rare long ones.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               stall_left <= $urandom_range(0, 3);
               rsp.ready <= 1'b0;
            end
            3: begin
               stall_left <= $urandom_range(20, 80);
               rsp.ready <= 1'b0;
            end
            default: rsp.ready <= 1'b1;
         endcase
      end
   end

   function automatic logic [fsg_pkg::WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic fsg_pkg::req_type noise_item();
      fsg_pkg::req_type r;
      r = fsg_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom}));
      return r;
   endfunction

   function automatic fsg_pkg::req_type fresh_identity();
      fsg_pkg::req_type r;
      r = noise_item();
      r.cmd = 1'b0;
      r.decode_ok = 1'b1;
      return r;
   endfunction

   function automatic fsg_pkg::req_type good_frame(fsg_pkg::req_type ident);
      fsg_pkg::req_type r;
      r = ident;
      r.cmd = 1'b0;
      r.decode_ok = 1'b1;
      r.generation = live_gen;
      seq_run = seq_run + $urandom_range(1, 4);
      time_run = time_run + $urandom_range(0, 3);
      r.sequence_number = seq_run;
      r.receipt_time = time_run;
      return r;
   endfunction

   task automatic send(fsg_pkg::req_type r, int gap);
      repeat (gap) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
      if (r.cmd) begin
         live_gen = live_gen + 1;
         foreach (pool[i]) pool[i] = fresh_identity();
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_reset();
      fsg_pkg::req_type r;
      r = noise_item();
      r.cmd = 1'b1;
      send(r, pick_gap());
   endtask

   initial begin
      fsg_pkg::req_type r;
      int gap;
      req.valid = 1'b0;
      req.payload = '0;
      foreach (pool[i]) pool[i] = fresh_identity();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: generation zero is always retired.
      r = good_frame(pool[0]);
      send(r, 0);
      send_reset();
      r = good_frame(pool[0]);
      r.decode_ok = 1'b0;
      send(r, 0);
      r = good_frame(pool[0]);
      send(r, 0);
      send(r, 1);                          // same sequence again is stale
      r.sequence_number = r.sequence_number + 1;
      r.receipt_time = r.receipt_time - 1; // clock going backwards
      send(r, 0);
      r = good_frame(pool[1]);
      r.generation = live_gen + 1;
      send(r, 0);
      r.generation = '0;
      send(r, 0);
      r = good_frame(pool[1]);
      send(r, 2);
      r = good_frame(pool[0]);
      send(r, 0);
      // All-ones identity, then all-zero identity at the field extremes.
      r = good_frame(pool[0]);
      {r.frame_source, r.frame_epoch, r.calib_code, r.representation,
       r.map_gen_id} = '1;
      r.sequence_number = fsg_pkg::WORD_MAX;
      r.receipt_time = fsg_pkg::WORD_MAX;
      send(r, 0);
      r.sequence_number = fsg_pkg::WORD_MAX - 1;
      send(r, 0);
      send_reset();
      r = good_frame(pool[0]);
      {r.frame_source, r.frame_epoch, r.calib_code, r.representation,
       r.map_gen_id} = '0;
      r.sequence_number = '0;
      r.receipt_time = '0;
      send(r, 0);
      send_reset();
      // Fill the identity table and push past it.
      for (int i = 0; i < fsg_pkg::HISTORY_DEPTH_DEFAULT + 3; i++) begin
         send(good_frame(fresh_identity()), 0);
      end

      for (int n = 0; n < 740; n++) begin
         gap = pick_gap();
         if (n == 250 || n == 500) begin
            // Hold off until every outstanding item has its result.
            req.valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         case ($urandom_range(0, 99)) inside
            [0:2]: send_reset();
            [3:6]: send(noise_item(), gap);
            [7:10]: begin
               r = good_frame(pool[$urandom_range(0, POOL_SIZE - 1)]);
               r.generation = $urandom_range(0, 1) ? rand64() : live_gen - 1;
               send(r, gap);
            end
            [11:14]: begin
               r = good_frame(pool[$urandom_range(0, POOL_SIZE - 1)]);
               r.decode_ok = 1'b0;
               send(r, gap);
            end
            [15:19]: begin
               r = good_frame(pool[$urandom_range(0, POOL_SIZE - 1)]);
               r.sequence_number = seq_run - $urandom_range(0, 20);
               send(r, gap);
            end
            [20:23]: begin
               r = good_frame(pool[$urandom_range(0, POOL_SIZE - 1)]);
               r.receipt_time = time_run - $urandom_range(1, 5);
               send(r, gap);
            end
            [24:29]: send(good_frame(fresh_identity()), gap);
            [30:31]: begin
               // A burst of new identities that may run the table full.
               for (int k = 0; k < 40; k++) send(good_frame(fresh_identity()), pick_gap());
            end
            default: send(good_frame(pool[$urandom_range(0, POOL_SIZE - 1)]), gap);
         endcase
      end
      req.valid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
